// ----- hdl/dmc_pkg.sv -----
// Shared constants and controller/datapath interface types for the
// direct-mapped cache tag checker. No dependencies.
package dmc_pkg;

    localparam int ADDR_W          = 32;
    localparam int COUNT_W         = 32;
    localparam int CFG_W           = 4;
    localparam int CFG_IDX_W       = 1;

    localparam int OFFSET_MIN      = 4;
    localparam int OFFSET_MAX      = 8;
    localparam int INDEX_MIN       = 4;

    localparam int MAX_LINES_DEF   = 16384;
    localparam int ADDR_WIDTH_DEF  = 32;

    localparam logic [CFG_W-1:0] OFFSET_RESET = 4'd4;
    localparam logic [CFG_W-1:0] INDEX_RESET  = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 1'b1;

    localparam logic ACTION_ACCESS = 1'b0;
    localparam logic ACTION_CLEAR  = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_TOP = {COUNT_W{1'b1}};

    typedef struct packed {
        logic acc_load;
        logic clr_load;
        logic mem_read;
        logic check;
        logic sweep_step;
    } dmc_cmd_t;

    typedef struct packed {
        logic sweep_last;
    } dmc_sts_t;

endpackage

// ----- hdl/dmc_ctrl.sv -----
// Sequencer for the cache tag checker: reset sweep, access and clear flow.
// Depends on dmc_pkg.
module dmc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            action,
    input  dmc_pkg::dmc_sts_t sts,
    output dmc_pkg::dmc_cmd_t cmd,
    output logic            busy,
    output logic            done
);
    import dmc_pkg::*;

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_CLEAR = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       done_reg;
    logic       done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg) inside
            S_IDLE:
            begin
                if (start)
                begin
                    if (action == ACTION_CLEAR)
                    begin
                        cmd.clr_load = 1'b1;
                        state_next   = S_CLEAR;
                    end
                    else
                    begin
                        cmd.acc_load = 1'b1;
                        state_next   = S_READ;
                    end
                end
            end
            S_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_INIT, S_CLEAR:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last)
                begin
                    done_next  = (state_reg == S_CLEAR);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

// ----- hdl/dmc_datapath.sv -----
// Tag memory, address split, configuration registers and saturating counters.
// Depends on dmc_pkg; driven by dmc_ctrl commands.
module dmc_datapath #(
    parameter int MAX_LINES  = dmc_pkg::MAX_LINES_DEF,
    parameter int ADDR_WIDTH = dmc_pkg::ADDR_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dmc_pkg::dmc_cmd_t             cmd,
    output dmc_pkg::dmc_sts_t             sts,
    input  logic                          cfg_we,
    input  logic [dmc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dmc_pkg::CFG_W-1:0]     cfg_data,
    input  logic [dmc_pkg::ADDR_W-1:0]    address,
    output logic                          hit,
    output logic [dmc_pkg::COUNT_W-1:0]   hit_count,
    output logic [dmc_pkg::COUNT_W-1:0]   miss_count,
    output logic [dmc_pkg::COUNT_W-1:0]   access_count
);
    import dmc_pkg::*;

    localparam int EFF_AW  = (ADDR_WIDTH < ADDR_W) ? ADDR_WIDTH : ADDR_W;
    localparam int TAG_W   = EFF_AW - OFFSET_MIN - INDEX_MIN;
    localparam int IDX_W   = $clog2(MAX_LINES);
    localparam int IDX_LIM = $clog2(MAX_LINES + 1) - 1;
    localparam int IB_W    = $clog2(IDX_LIM + 1);
    localparam int SH_W    = $clog2(OFFSET_MAX + IDX_LIM + 1);

    logic [CFG_W-1:0]   offset_bits_reg;
    logic [CFG_W-1:0]   index_bits_reg;
    logic [CFG_W-1:0]   ob_c;
    logic [IB_W-1:0]    ib_c;
    logic [SH_W-1:0]    sh;
    logic [EFF_AW-1:0]  addr_m;
    logic [EFF_AW-1:0]  idx_shift;
    logic [EFF_AW-1:0]  tag_shift;
    logic [IDX_W-1:0]   idx_mask;
    logic [IDX_W-1:0]   idx_calc;
    logic [IDX_W-1:0]   idx_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [TAG_W:0]     rd_reg;
    logic [IDX_W-1:0]   sweep_cnt_reg;
    logic [IDX_W-1:0]   sweep_cnt_next;
    logic               hit_calc;
    logic               hit_reg;
    logic               hit_next;
    logic [COUNT_W-1:0] hits_reg;
    logic [COUNT_W-1:0] hits_next;
    logic [COUNT_W-1:0] misses_reg;
    logic [COUNT_W-1:0] misses_next;
    logic [COUNT_W-1:0] accesses_reg;
    logic [COUNT_W-1:0] accesses_next;

    logic [TAG_W:0] tag_mem [MAX_LINES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= OFFSET_RESET;
            index_bits_reg  <= INDEX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                CFG_INDEX_BITS:  index_bits_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        if (int'(offset_bits_reg) < OFFSET_MIN)
            ob_c = CFG_W'(OFFSET_MIN);
        else if (int'(offset_bits_reg) > OFFSET_MAX)
            ob_c = CFG_W'(OFFSET_MAX);
        else
            ob_c = offset_bits_reg;

        if (int'(index_bits_reg) > IDX_LIM)
            ib_c = IB_W'(IDX_LIM);
        else if (int'(index_bits_reg) < INDEX_MIN)
            ib_c = IB_W'(INDEX_MIN);
        else
            ib_c = IB_W'(index_bits_reg);
    end

    assign sh        = SH_W'(ob_c) + SH_W'(ib_c);
    assign addr_m    = address[EFF_AW-1:0];
    assign idx_shift = addr_m >> ob_c;
    assign tag_shift = addr_m >> sh;
    assign idx_mask  = ~({IDX_W{1'b1}} << ib_c);
    assign idx_calc  = idx_shift[IDX_W-1:0] & idx_mask;

    always_ff @(posedge clk)
    begin
        if (cmd.acc_load)
        begin
            idx_reg <= idx_calc;
            tag_reg <= tag_shift[TAG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_read)
            rd_reg <= tag_mem[idx_reg];
    end

    assign hit_calc = rd_reg[TAG_W] && (rd_reg[TAG_W-1:0] == tag_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.sweep_step)
            tag_mem[sweep_cnt_reg] <= '0;
        else if (cmd.check && !hit_calc)
            tag_mem[idx_reg] <= {1'b1, tag_reg};
    end

    always_comb
    begin
        sweep_cnt_next = sweep_cnt_reg;
        if (cmd.clr_load)
            sweep_cnt_next = '0;
        else if (cmd.sweep_step)
            sweep_cnt_next = sweep_cnt_reg + 1'b1;
    end

    always_comb
    begin
        hit_next      = hit_reg;
        hits_next     = hits_reg;
        misses_next   = misses_reg;
        accesses_next = accesses_reg;
        if (cmd.clr_load)
        begin
            hit_next      = 1'b0;
            hits_next     = '0;
            misses_next   = '0;
            accesses_next = '0;
        end
        else if (cmd.check)
        begin
            hit_next = hit_calc;
            if (hit_calc && hits_reg != COUNT_TOP)
                hits_next = hits_reg + 1'b1;
            if (!hit_calc && misses_reg != COUNT_TOP)
                misses_next = misses_reg + 1'b1;
            if (accesses_reg != COUNT_TOP)
                accesses_next = accesses_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
            hit_reg       <= 1'b0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            accesses_reg  <= '0;
        end
        else
        begin
            sweep_cnt_reg <= sweep_cnt_next;
            hit_reg       <= hit_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            accesses_reg  <= accesses_next;
        end
    end

    assign sts.sweep_last = (sweep_cnt_reg == IDX_W'(MAX_LINES - 1));
    assign hit            = hit_reg;
    assign hit_count      = hits_reg;
    assign miss_count     = misses_reg;
    assign access_count   = accesses_reg;

endmodule

// ----- hdl/direct_mapped_cache_tag_check_top.sv -----
// Top level of the direct-mapped cache tag checker.
// Depends on dmc_pkg, dmc_ctrl and dmc_datapath.
//
// Usage:
//   A word is taken at a rising edge with start high and busy low. action
//   selects an access of address or a clear of all lines and counters.
//   Each word yields one result, shown for one cycle with done high: hit and
//   the saturating hit, miss and access counts after that word. The receiver
//   cannot stall; results are not held.
//   Busy drops with done, so a new access is taken only once the last one
//   has shown its result: the tag memory is read in one cycle and compared
//   and written back in the next, through one port.
//   A clear walks the tag memory one line per cycle and shows done once the
//   last line is cleared.
//   After reset the same walk invalidates every line,
//   with busy high and no result; configuration writes are taken at any time
//   through cfg_we, cfg_index and cfg_data, and are meant to be made while
//   the block is idle.
module direct_mapped_cache_tag_check_top #(
    parameter int MAX_LINES  = dmc_pkg::MAX_LINES_DEF,
    parameter int ADDR_WIDTH = dmc_pkg::ADDR_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          action,
    input  logic [dmc_pkg::ADDR_W-1:0]    address,
    output logic                          done,
    output logic                          hit,
    output logic [dmc_pkg::COUNT_W-1:0]   hit_count,
    output logic [dmc_pkg::COUNT_W-1:0]   miss_count,
    output logic [dmc_pkg::COUNT_W-1:0]   access_count,
    input  logic                          cfg_we,
    input  logic [dmc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dmc_pkg::CFG_W-1:0]     cfg_data
);
    import dmc_pkg::*;

    dmc_cmd_t cmd;
    dmc_sts_t sts;

    dmc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    dmc_datapath #(
        .MAX_LINES  (MAX_LINES),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .address      (address),
        .hit          (hit),
        .hit_count    (hit_count),
        .miss_count   (miss_count),
        .access_count (access_count)
    );

endmodule

// ----- hdl/dmc_checker.sv -----
// Port-level assertions for the cache tag checker, bound to the top level.
// Depends on dmc_pkg and direct_mapped_cache_tag_check_top.
module dmc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        action,
    input logic                        done,
    input logic                        hit,
    input logic [dmc_pkg::COUNT_W-1:0] hit_count,
    input logic [dmc_pkg::COUNT_W-1:0] miss_count,
    input logic [dmc_pkg::COUNT_W-1:0] access_count
);
    import dmc_pkg::*;

    a_access_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == ACTION_ACCESS) |-> ##3 done)
        else $error("access result not shown three cycles after start");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_counts_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hit_count <= access_count && miss_count <= access_count))
        else $error("hit or miss count exceeds access count");

    a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> (hit_count != '0))
        else $error("hit reported with zero hit count");

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == ACTION_CLEAR) |=> (busy && !done))
        else $error("clear did not hold busy");

endmodule

bind direct_mapped_cache_tag_check_top dmc_checker u_dmc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .done         (done),
    .hit          (hit),
    .hit_count    (hit_count),
    .miss_count   (miss_count),
    .access_count (access_count)
);
